// File: sv/lpg_pkg.sv
// Package for the Lorentzian peak and gradient core: widths, constants, register indexes.
// No dependencies; imported by the top level, lpg_mul and lpg_div.
package lpg_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CHUNK_W       = 32;   // multiplier slice width
	localparam int Q_W           = 32;   // quotient width of the dividers
	localparam int DIV_LAT       = Q_W + 1;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

endpackage

// File: sv/lorentzian_peak_and_gradient_core.sv
// Top level of the Lorentzian peak and gradient core.
// Depends on lpg_pkg, lpg_mul, lpg_div and lpg_dly.
//
// Usage:
//  - cfg channel writes center (index 0), half_width (1) and scale (2); cfg_ready is always
//    high. Write only while the pipeline holds no item. Other indexes are dropped.
//  - s_axis carries one sample position x_pos per item (signed Q16.16 at default FRAC_BITS).
//  - m_axis returns one item per input: value, d_center, d_width, d_scale in tdata, and the
//    zero_denominator and saturated flags in tuser.
//  - Depth: a result reaches the output register through three chained 2-stage multipliers
//    and a 33-stage restoring divider (an overflow check, then one quotient bit per stage).
//  - Throughput: one item per cycle, back to back, while the output is taken.
//  - Stall: the whole pipeline advances only while the output register is empty or being
//    taken; s_axis_tready follows that, so nothing is dropped or repeated.
//  - Reset (arst_n low): all valid bits clear, registers return to center 0, half_width 1.0,
//    scale 1.0.
//  - Zero denominator (x == center and half_width == 0): all values 0, flag set.
module lorentzian_peak_and_gradient_core #(
	parameter int FRAC_BITS = lpg_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,  // [31:0] x_pos
	// output stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [127:0]                   m_axis_tdata,  // value, d_center, d_width, d_scale
	output logic [1:0]                     m_axis_tuser   // [0] zero_denominator, [1] saturated
);
	import lpg_pkg::*;

	localparam int AW    = 34;          // 2*|x-c|
	localparam int BW    = 31;
	localparam int SW    = 32;
	localparam int PW    = 32;
	localparam int A2W   = 2 * AW;
	localparam int B2W   = 2 * BW;
	localparam int SBW   = SW + BW;
	localparam int D2W   = A2W;         // a^2 + b^2 < 2^67
	localparam int DEN1W = PW + D2W;
	localparam int D2QW  = 2 * D2W;
	localparam int DEN2W = PW + D2QW;
	localparam int NCW   = SBW + AW;
	localparam int NWW   = SW + D2W;
	localparam int NUMVW = SBW + FRAC_BITS + 31;
	localparam int NUMSW = BW + 2 * FRAC_BITS + 31;
	localparam int NUMCW = NCW + 2 * FRAC_BITS + 33;
	localparam int NUMWW = NWW + 2 * FRAC_BITS + 31;
	localparam int FLG_LAT = 4 + DIV_LAT;          // from stage 4 to divider output
	localparam int VLD_LAT = 7 + DIV_LAT;          // from stage 1 to divider output

	// ---------------- configuration registers
	logic [31:0]   center_q;
	logic [BW-1:0] half_width_q;
	logic [31:0]   scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q     <= '0;
			half_width_q <= BW'(1) << FRAC_BITS;
			scale_q      <= 32'(1) << FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTER:     center_q     <= cfg_data;
				CFG_HALF_WIDTH: half_width_q <= cfg_data[BW-1:0];
				CFG_SCALE:      scale_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- global advance: output register empty or being taken
	logic out_valid_q;
	logic en;
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: offset and magnitudes
	logic [32:0]   dx;
	logic [32:0]   dmag;
	logic [SW-1:0] smag_c;
	assign dx     = {s_axis_tdata[31], s_axis_tdata} - {center_q[31], center_q};
	assign dmag   = dx[32] ? (~dx + 33'd1) : dx;
	assign smag_c = scale_q[31] ? (~scale_q + 32'd1) : scale_q;

	logic          v_s1;
	logic [AW-1:0] a_s1;
	logic [BW-1:0] b_s1;
	logic [SW-1:0] smag_s1;
	logic          sneg_s1, aneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= {dmag, 1'b0};
			b_s1    <= half_width_q;
			smag_s1 <= smag_c;
			sneg_s1 <= scale_q[31];
			aneg_s1 <= dx[32];
		end
	end

	// ---------------- stages 2-3: squares and S*b
	logic [A2W-1:0] a2_s3;
	logic [B2W-1:0] b2_s3;
	logic [SBW-1:0] sb_s3;

	lpg_mul #(.WA(AW), .WB(AW)) u_mul_aa (.clk, .en, .a(a_s1), .b(a_s1), .p(a2_s3));
	lpg_mul #(.WA(BW), .WB(BW)) u_mul_bb (.clk, .en, .a(b_s1), .b(b_s1), .p(b2_s3));
	lpg_mul #(.WA(SW), .WB(BW)) u_mul_sb (.clk, .en, .a(smag_s1), .b(b_s1), .p(sb_s3));

	logic [AW+BW+SW+1:0] side_s3;
	lpg_dly #(.W(AW+BW+SW+2), .N(2)) u_dly_side (
		.clk, .arst_n, .en,
		.d({a_s1, b_s1, smag_s1, sneg_s1, aneg_s1}),
		.q(side_s3)
	);

	// ---------------- stage 4: denominator base, width numerator term
	logic [D2W-1:0] d2_s4;
	logic [D2W-1:0] dif_s4;
	logic           dneg_s4, zero_s4;
	logic [SBW-1:0] sb_s4;
	logic [AW-1:0]  a_s4;
	logic [BW-1:0]  b_s4;
	logic [SW-1:0]  smag_s4;
	logic           sneg_s4, aneg_s4;
	logic           lt_c;
	assign lt_c = A2W'(b2_s3) > a2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s4   <= D2W'(a2_s3 + A2W'(b2_s3));
			dif_s4  <= lt_c ? (A2W'(b2_s3) - a2_s3) : (a2_s3 - A2W'(b2_s3));
			dneg_s4 <= lt_c;
			zero_s4 <= (a2_s3 == '0) && (b2_s3 == '0);
			sb_s4   <= sb_s3;
			{a_s4, b_s4, smag_s4, sneg_s4, aneg_s4} <= side_s3;
		end
	end

	// ---------------- stages 5-6: pi*D, D^2 and numerators
	logic [DEN1W-1:0] den1_s6;
	logic [D2QW-1:0]  d2q_s6;
	logic [NCW-1:0]   nc_s6;
	logic [NWW-1:0]   nw_s6;

	lpg_mul #(.WA(PW), .WB(D2W)) u_mul_den1 (.clk, .en, .a(PI_Q30), .b(d2_s4), .p(den1_s6));
	lpg_mul #(.WA(D2W), .WB(D2W)) u_mul_d2q (.clk, .en, .a(d2_s4), .b(d2_s4), .p(d2q_s6));
	lpg_mul #(.WA(SBW), .WB(AW)) u_mul_nc (.clk, .en, .a(sb_s4), .b(a_s4), .p(nc_s6));
	lpg_mul #(.WA(SW), .WB(D2W)) u_mul_nw (.clk, .en, .a(smag_s4), .b(dif_s4), .p(nw_s6));

	// ---------------- stages 7-8: pi*D^2, alignment of the rest
	logic [DEN2W-1:0] den2_s8;
	logic [DEN1W-1:0] den1_s8;
	logic [NCW-1:0]   nc_s8;
	logic [NWW-1:0]   nw_s8;
	logic [SBW-1:0]   sb_s8;
	logic [BW-1:0]    b_s8;

	lpg_mul #(.WA(PW), .WB(D2QW)) u_mul_den2 (.clk, .en, .a(PI_Q30), .b(d2q_s6), .p(den2_s8));

	lpg_dly #(.W(DEN1W+NCW+NWW), .N(2)) u_dly_num (
		.clk, .arst_n, .en,
		.d({den1_s6, nc_s6, nw_s6}),
		.q({den1_s8, nc_s8, nw_s8})
	);
	lpg_dly #(.W(SBW+BW), .N(4)) u_dly_sb (
		.clk, .arst_n, .en,
		.d({sb_s4, b_s4}),
		.q({sb_s8, b_s8})
	);

	// ---------------- dividers
	logic [Q_W-1:0] qv, qc, qw, qs;
	logic           ov_v, ov_c, ov_w, ov_s;

	lpg_div #(.NUM_W(NUMVW), .DEN_W(DEN1W)) u_div_value (
		.clk, .en, .num({sb_s8, {(FRAC_BITS+31){1'b0}}}), .den(den1_s8),
		.quo(qv), .ovf(ov_v)
	);
	lpg_div #(.NUM_W(NUMCW), .DEN_W(DEN2W)) u_div_center (
		.clk, .en, .num({nc_s8, {(2*FRAC_BITS+33){1'b0}}}), .den(den2_s8),
		.quo(qc), .ovf(ov_c)
	);
	lpg_div #(.NUM_W(NUMWW), .DEN_W(DEN2W)) u_div_width (
		.clk, .en, .num({nw_s8, {(2*FRAC_BITS+31){1'b0}}}), .den(den2_s8),
		.quo(qw), .ovf(ov_w)
	);
	lpg_div #(.NUM_W(NUMSW), .DEN_W(DEN1W)) u_div_scale (
		.clk, .en, .num({b_s8, {(2*FRAC_BITS+31){1'b0}}}), .den(den1_s8),
		.quo(qs), .ovf(ov_s)
	);

	// sign and zero flags, valid, aligned to divider outputs
	logic zero_d, dneg_d, aneg_d, sneg_d, v_d;
	lpg_dly #(.W(4), .N(FLG_LAT)) u_dly_flg (
		.clk, .arst_n, .en,
		.d({zero_s4, dneg_s4, aneg_s4, sneg_s4}),
		.q({zero_d, dneg_d, aneg_d, sneg_d})
	);
	lpg_dly #(.W(1), .N(VLD_LAT)) u_dly_vld (
		.clk, .arst_n, .en, .d(v_s1), .q(v_d)
	);

	// ---------------- sign and saturation: {sat, value}
	function automatic logic [32:0] clip(input logic [Q_W-1:0] q, input logic ovf,
		input logic neg);
		logic sat;
		logic [31:0] v;
		if (neg) begin
			sat = ovf || (q > 32'h8000_0000);
			v   = sat ? 32'h8000_0000 : (~q + 32'd1);
		end else begin
			sat = ovf || q[31];
			v   = sat ? 32'h7FFF_FFFF : q;
		end
		return {sat, v};
	endfunction

	logic [32:0] rv, rc, rw, rs;
	assign rv = clip(qv, ov_v, sneg_d);
	assign rc = clip(qc, ov_c, sneg_d ^ aneg_d);
	assign rw = clip(qw, ov_w, sneg_d ^ dneg_d);
	assign rs = clip(qs, ov_s, 1'b0);

	// ---------------- output register
	logic [127:0] tdata_q;
	logic [1:0]   tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_d) begin
				tdata_q <= '0;
				tuser_q <= 2'b01;
			end else begin
				tdata_q <= {rs[31:0], rw[31:0], rc[31:0], rv[31:0]};
				tuser_q <= {rv[32] | rc[32] | rw[32] | rs[32], 1'b0};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
endmodule

// File: sv/lpg_dly.sv
// Enable-gated delay line used to keep side data aligned with the arithmetic stages.
// Depends on nothing but the clock and reset.
module lpg_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] dly_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) dly_s[i] <= '0;
		end else if (en) begin
			dly_s[0] <= d;
			for (int i = 1; i < N; i++) dly_s[i] <= dly_s[i-1];
		end
	end

	assign q = dly_s[N-1];
endmodule

// File: sv/lpg_mul.sv
// Two-stage unsigned multiplier: 32x32 slice products, then a registered shifted sum.
// Depends on lpg_pkg (CHUNK_W).
module lpg_mul #(
	parameter int WA = 32,
	parameter int WB = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [WA-1:0]   a,
	input  logic [WB-1:0]   b,
	output logic [WA+WB-1:0] p
);
	import lpg_pkg::*;

	localparam int NA = (WA + CHUNK_W - 1) / CHUNK_W;
	localparam int NB = (WB + CHUNK_W - 1) / CHUNK_W;
	localparam int PW = (NA + NB) * CHUNK_W;

	logic [NA*CHUNK_W-1:0] a_x;
	logic [NB*CHUNK_W-1:0] b_x;
	logic [2*CHUNK_W-1:0]  pp_s1 [NA*NB];
	logic [PW-1:0]         acc;
	logic [WA+WB-1:0]      p_s2;

	assign a_x = (NA*CHUNK_W)'(a);
	assign b_x = (NB*CHUNK_W)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i*NB+j] <= (2*CHUNK_W)'(a_x[i*CHUNK_W +: CHUNK_W]) *
						(2*CHUNK_W)'(b_x[j*CHUNK_W +: CHUNK_W]);
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++)
			for (int j = 0; j < NB; j++)
				acc = acc + (PW'(pp_s1[i*NB+j]) << (CHUNK_W*(i+j)));
	end

	always_ff @(posedge clk) begin
		if (en) p_s2 <= acc[WA+WB-1:0];
	end

	assign p = p_s2;
endmodule

// File: sv/lpg_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on lpg_pkg (Q_W).
module lpg_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]          den,
	output logic [lpg_pkg::Q_W-1:0]   quo,
	output logic                      ovf
);
	import lpg_pkg::*;

	localparam int RW = DEN_W + Q_W;
	localparam int CW = (NUM_W > RW) ? NUM_W : RW;

	logic [CW-1:0]    num_c;
	logic [CW-1:0]    lim_c;
	logic             ovf_c;
	logic [RW-1:0]    rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W+1];
	logic             ovf_s [Q_W+1];

	// quotient fits Q_W bits only when num < den * 2^Q_W
	assign num_c = CW'(num);
	assign lim_c = CW'({den, {Q_W{1'b0}}});
	assign ovf_c = num_c >= lim_c;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf_c ? '0 : num_c[RW-1:0];
			den_s[0] <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= ovf_c;
		end
	end

	for (genvar g = 0; g < Q_W; g++) begin : g_step
		localparam int K = Q_W - 1 - g;
		logic [RW-1:0] sub;
		logic          ge;
		assign sub = RW'(den_s[g]) << K;
		assign ge  = rem_s[g] >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g+1]   <= q_s[g] | (ge ? (Q_W'(1) << K) : '0);
				ovf_s[g+1] <= ovf_s[g];
			end
		end

		if (g < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= ge ? (rem_s[g] - sub) : rem_s[g];
					den_s[g+1] <= den_s[g];
				end
			end
		end
	end

	assign quo = q_s[Q_W];
	assign ovf = ovf_s[Q_W];
endmodule

// File: sv/lpg_chk.sv
// Port-level checker for the Lorentzian peak and gradient core, bound to the top level.
// Depends only on the top level's ports.
module lpg_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);
	// a result held back by the receiver stays unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// input side opens exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	// a zero denominator forces every value and the saturation flag to zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
		else $error("zero denominator result not cleared");

	// the scale derivative is never negative
	a_dscale: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[127])
		else $error("negative scale derivative");
endmodule

bind lorentzian_peak_and_gradient_core lpg_chk u_lpg_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
